/* src/bde_pkg.sv */
// Shared types and constants for the button debounce and event detector.
// No dependencies; every other file imports this package.
package bde_pkg;

  localparam int EV_MAX = 4;
  localparam int CNT_W  = $clog2(EV_MAX + 1);
  localparam int IDX_W  = $clog2(EV_MAX);

  typedef enum logic [2:0] {
    EV_PRESSING  = 3'd0,
    EV_PRESS     = 3'd1,
    EV_TOGGLE    = 3'd2,
    EV_DOUBLE    = 3'd3,
    EV_HOLD      = 3'd4,
    EV_RELEASING = 3'd5,
    EV_RELEASE   = 3'd6
  } ev_code_t;

  localparam logic [1:0] REG_PRESS_LEVEL  = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE     = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;
  localparam logic [1:0] REG_HOLD         = 2'd3;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_of_poll;
  } evt_t;

  typedef struct packed {
    logic        press_level;
    logic [15:0] debounce_ms;
    logic [15:0] double_click_ms;
    logic [15:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]         count;
    ev_code_t [EV_MAX-1:0]    codes;
  } ev_batch_t;

endpackage

/* src/bde_eval.sv */
// Per-poll evaluation: debounce state registers and the event list of one poll.
// Depends on bde_pkg.
module bde_eval
  import bde_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  poll_t     poll,
  input  cfg_t      cfg,
  input  logic      commit,
  output ev_batch_t batch
);

  logic                  seen_first;
  logic                  prev_level;
  logic [TIME_WIDTH-1:0] stable_since;
  logic [TIME_WIDTH-1:0] last_press_time;
  logic [TIME_WIDTH-1:0] hold_start;
  logic                  edge_armed;
  logic                  hold_armed;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] el_stable;
  logic [TIME_WIDTH-1:0] el_press;
  logic [TIME_WIDTH-1:0] el_hold;
  logic                  ref_level;
  logic                  changed;
  logic                  settled;
  logic                  pressed;
  logic                  dbl;
  logic                  hold_fire;

  assign now_t     = TIME_WIDTH'(poll.now_ms);
  // The very first poll takes its own level as the reference, so it never sees an edge.
  assign ref_level = seen_first ? prev_level : poll.pin_level;
  assign changed   = poll.pin_level != ref_level;
  assign el_stable = now_t - stable_since;
  assign el_press  = now_t - last_press_time;
  assign el_hold   = now_t - hold_start;
  assign settled   = !changed && (el_stable > TIME_WIDTH'(cfg.debounce_ms));
  assign pressed   = poll.pin_level == cfg.press_level;
  assign dbl       = el_press < TIME_WIDTH'(cfg.double_click_ms);
  // On the poll of the press the hold timer restarts at zero, so hold can only
  // fire on a poll without an armed edge.
  assign hold_fire = !edge_armed && hold_armed && (el_hold > TIME_WIDTH'(cfg.hold_ms));

  always_comb begin
    batch.count    = '0;
    batch.codes[0] = EV_PRESSING;
    batch.codes[1] = EV_PRESS;
    batch.codes[2] = EV_TOGGLE;
    batch.codes[3] = EV_DOUBLE;
    if (settled) begin
      if (pressed) begin
        if (edge_armed) begin
          batch.count = dbl ? CNT_W'(4) : CNT_W'(3);
        end else begin
          batch.codes[1] = EV_HOLD;
          batch.count    = hold_fire ? CNT_W'(2) : CNT_W'(1);
        end
      end else begin
        batch.codes[0] = EV_RELEASING;
        batch.codes[1] = EV_RELEASE;
        batch.count    = edge_armed ? CNT_W'(3) : CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first      <= 1'b0;
      prev_level      <= 1'b0;
      stable_since    <= '0;
      last_press_time <= '0;
      hold_start      <= '0;
      edge_armed      <= 1'b0;
      hold_armed      <= 1'b0;
    end else if (commit) begin
      seen_first <= 1'b1;
      prev_level <= poll.pin_level;
      if (changed) begin
        stable_since <= now_t;
        edge_armed   <= 1'b1;
      end else if (settled) begin
        if (pressed) begin
          if (edge_armed) begin
            edge_armed      <= 1'b0;
            last_press_time <= now_t;
            hold_start      <= now_t;
            hold_armed      <= 1'b1;
          end else if (hold_fire) begin
            hold_armed <= 1'b0;
          end
        end else begin
          edge_armed <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/bde_evq.sv */
// Result register: holds the event list of one poll and sends it one event per transfer.
// Depends on bde_pkg.
module bde_evq
  import bde_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  ev_batch_t batch,
  output logic      free,
  output logic      evt_valid,
  input  logic      evt_stall,
  output evt_t      evt
);

  logic                  valid_q;
  logic [CNT_W-1:0]      count;
  ev_code_t [EV_MAX-1:0] codes;
  logic [IDX_W-1:0]      idx;
  logic                  last;
  logic                  take;

  assign last = idx == IDX_W'(count - CNT_W'(1));
  assign take = valid_q && !evt_stall;
  // A new list may land in the same cycle that the final event of the old one leaves.
  assign free = !valid_q || (take && last);

  assign evt_valid        = valid_q;
  assign evt.event_code   = codes[idx];
  assign evt.last_of_poll = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx     <= '0;
      count   <= batch.count;
      codes   <= batch.codes;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

/* src/button_debounce_event_detector.sv */
// Top level of the button debounce and event detector: poll register, configuration
// registers, evaluation stage and event output register. Depends on bde_pkg, bde_eval, bde_evq.
//
//   channel  direction  handshake               payload
//   poll     in         poll_valid / poll_stall  pin_level, now_ms
//   evt      out        evt_valid / evt_stall    event_code, last_of_poll
//   cfg      in         cfg_we                   cfg_index, cfg_data
//
// A poll is held in the poll register and evaluated from there; its events leave one per
// cycle while evt_stall is low, up to four events per poll and none if nothing happened.
// The event output register paces the polls; a poll enters while events still drain.
// Reset (rst, synchronous) clears all detector state and loads the default settings.
// A stall on the event side backs up into the poll register and then into poll_stall.
module button_debounce_event_detector
  import bde_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        poll_valid,
  output logic        poll_stall,
  input  poll_t       poll,
  output logic        evt_valid,
  input  logic        evt_stall,
  output evt_t        evt,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic      a_valid;
  poll_t     a_poll;
  cfg_t      cfg;
  ev_batch_t batch;
  logic      free;
  logic      adv;
  logic      commit;
  logic      load;

  assign adv        = free || (batch.count == '0);
  assign commit     = a_valid && adv;
  assign load       = commit && (batch.count != '0);
  assign poll_stall = a_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!poll_stall) begin
      a_valid <= poll_valid;
      if (poll_valid) begin
        a_poll <= poll;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level     <= 1'b1;
      cfg.debounce_ms     <= 16'd5;
      cfg.double_click_ms <= 16'd250;
      cfg.hold_ms         <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_LEVEL:  cfg.press_level     <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        REG_HOLD:         cfg.hold_ms         <= cfg_data;
        default: ;
      endcase
    end
  end

  bde_eval #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_eval (
    .clk   (clk),
    .rst   (rst),
    .poll  (a_poll),
    .cfg   (cfg),
    .commit(commit),
    .batch (batch)
  );

  bde_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .batch    (batch),
    .free     (free),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt      (evt)
  );

  // A held poll stays in the poll register until it is evaluated.
  a_poll_held: assert property (@(posedge clk) disable iff (rst)
    poll_stall |=> a_valid)
    else $error("poll register lost a stalled poll");

  // A loaded event list shows up on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> evt_valid)
    else $error("loaded event list not presented");

  // Events of one poll follow without a gap until the final one.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_stall && !evt.last_of_poll) |=> evt_valid)
    else $error("event list broken off before its final event");

  // After the final event the output goes idle unless a new list was loaded.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_stall && evt.last_of_poll && !load) |=> !evt_valid)
    else $error("event repeated after the final transfer of a poll");

endmodule

/* test/testbench.sv */
// Self-checking testbench for button_debounce_event_detector: directed and random polls,
// an event predictor with its own state, and a per-field check of every event transfer.
// Depends on bde_pkg and the RTL under src.
module testbench;
  import bde_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        poll_valid = 1'b0;
  logic        poll_stall;
  poll_t       poll = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  evt_t        evt;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_debounce_event_detector dut (
    .clk        (clk),
    .rst        (rst),
    .poll_valid (poll_valid),
    .poll_stall (poll_stall),
    .poll       (poll),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor copy of the settings and the detector state.
  logic        cfg_active = 1'b1;
  logic [15:0] cfg_debounce = 16'd5;
  logic [15:0] cfg_double = 16'd250;
  logic [15:0] cfg_hold = 16'd500;

  logic        seen_first = 1'b0;
  logic        prev_level = 1'b0;
  logic [31:0] stable_since = '0;
  logic [31:0] last_press_time = '0;
  logic [31:0] hold_start = '0;
  logic        edge_armed = 1'b0;
  logic        hold_armed = 1'b0;

  poll_t pending_polls[$];
  evt_t  expected_events[$];

  int          err_count = 0;
  int          cycle_count = 0;
  int          polls_in = 0;
  int          polls_queued = 0;
  logic        poll_taken = 1'b0;
  logic        calm = 1'b0;
  logic [31:0] clock_ms = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Works out the events of one poll and appends them to the expected events.
  task automatic debounce_events(input poll_t p);
    ev_code_t    codes[$];
    logic        lvl;
    logic [31:0] now;
    logic [31:0] dt;
    evt_t        e;
    lvl = p.pin_level;
    now = p.now_ms;
    if (!seen_first) begin
      seen_first = 1'b1;
      prev_level = lvl;
    end
    dt = now - stable_since;
    if (lvl != prev_level) begin
      prev_level = lvl;
      stable_since = now;
      edge_armed = 1'b1;
    end else if (dt > {16'd0, cfg_debounce}) begin
      if (lvl == cfg_active) begin
        codes.push_back(EV_PRESSING);
        if (edge_armed) begin
          edge_armed = 1'b0;
          codes.push_back(EV_PRESS);
          codes.push_back(EV_TOGGLE);
          dt = now - last_press_time;
          if (dt < {16'd0, cfg_double}) codes.push_back(EV_DOUBLE);
          last_press_time = now;
          hold_armed = 1'b1;
          hold_start = now;
        end
        dt = now - hold_start;
        if (hold_armed && dt > {16'd0, cfg_hold}) begin
          hold_armed = 1'b0;
          codes.push_back(EV_HOLD);
        end
      end else begin
        codes.push_back(EV_RELEASING);
        if (edge_armed) begin
          edge_armed = 1'b0;
          codes.push_back(EV_RELEASE);
          codes.push_back(EV_TOGGLE);
        end
      end
    end
    for (int i = 0; i < codes.size(); i++) begin
      e.event_code = codes[i];
      e.last_of_poll = (i == codes.size() - 1);
      expected_events.push_back(e);
    end
  endtask

  // Sender: offers the next pending poll once the previous one has been transferred.
  always @(negedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (!poll_valid || poll_taken) begin
      if (pending_polls.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        poll <= pending_polls.pop_front();
        poll_valid <= 1'b1;
      end else begin
        poll_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the block backs up into poll_stall.
  int   long_hold_left = 0;
  logic long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (!long_hold_done && polls_in >= 60) begin
      long_hold_done = 1'b1;
      long_hold_left = 300;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      evt_stall <= 1'b1;
    end else begin
      evt_stall <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin : monitor
    evt_t want;
    if (rst) begin
      poll_taken <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event %0d with nothing expected", evt.event_code));
        end else begin
          want = expected_events.pop_front();
          if (evt.event_code !== want.event_code)
            report_mismatch($sformatf("event_code %0d, expected %0d",
                                      evt.event_code, want.event_code));
          if (evt.last_of_poll !== want.last_of_poll)
            report_mismatch($sformatf("last_of_poll %0b, expected %0b",
                                      evt.last_of_poll, want.last_of_poll));
        end
      end
      poll_taken <= poll_valid && !poll_stall;
      if (poll_valid && !poll_stall) begin
        debounce_events(poll);
        polls_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_poll(input logic lvl, input int unsigned step);
    poll_t p;
    clock_ms = clock_ms + step;
    p.pin_level = lvl;
    p.now_ms = clock_ms;
    pending_polls.push_back(p);
    polls_queued++;
  endtask

  task automatic push_at(input logic lvl, input logic [31:0] at_ms);
    clock_ms = at_ms;
    push_poll(lvl, 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PRESS_LEVEL:  cfg_active = val[0];
      REG_DEBOUNCE:     cfg_debounce = val;
      REG_DOUBLE_CLICK: cfg_double = val;
      REG_HOLD:         cfg_hold = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic act, input logic [15:0] deb, input logic [15:0] dbl,
                           input logic [15:0] hld);
    write_reg(REG_PRESS_LEVEL, {15'd0, act});
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DOUBLE_CLICK, dbl);
    write_reg(REG_HOLD, hld);
  endtask

  // A press with bounce, sometimes a hold near the hold time, a release with bounce and a gap
  // that mostly lands around the double-click window.
  task automatic queue_gesture();
    int   n;
    int   hold_step;
    logic pressed;
    pressed = cfg_active;
    n = $urandom_range(0, 3);
    repeat (n) begin
      push_poll(pressed, $urandom_range(0, 2));
      push_poll(!pressed, $urandom_range(0, 2));
    end
    push_poll(pressed, $urandom_range(0, 3));
    push_poll(pressed, cfg_debounce + $urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) begin
      hold_step = int'(cfg_hold) + int'($urandom_range(0, 2)) - 1;
      if (hold_step < 0) hold_step = 0;
      push_poll(pressed, hold_step);
    end
    n = $urandom_range(0, 3);
    repeat (n) push_poll(pressed, $urandom_range(0, 3));
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_poll(!pressed, $urandom_range(0, 2));
      push_poll(pressed, $urandom_range(0, 2));
    end
    push_poll(!pressed, $urandom_range(0, 3));
    push_poll(!pressed, cfg_debounce + $urandom_range(0, 2));
    n = $urandom_range(0, 3);
    repeat (n) push_poll(!pressed, $urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, cfg_double + 10);
  endtask

  task automatic queue_random(input int count);
    int start;
    poll_t p;
    start = polls_queued;
    while (polls_queued - start < count) begin
      if ($urandom_range(0, 99) < 15) begin
        p.pin_level = 1'($urandom_range(0, 1));
        p.now_ms = $urandom;
        pending_polls.push_back(p);
        polls_queued++;
      end else begin
        queue_gesture();
      end
    end
  endtask

  task automatic wait_drained();
    while (polls_in != polls_queued || expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed polls at the reset settings: first poll, bounce, double click, hold,
    // release, and a time wrap.
    push_at(1'b1, 32'd100);
    push_at(1'b1, 32'd101);
    push_at(1'b0, 32'd102);
    push_at(1'b1, 32'd103);
    push_at(1'b1, 32'd106);
    push_at(1'b1, 32'd109);
    push_at(1'b1, 32'd700);
    push_at(1'b0, 32'd710);
    push_at(1'b0, 32'd720);
    push_at(1'b1, 32'd800);
    push_at(1'b1, 32'd806);
    push_at(1'b0, 32'd900);
    push_at(1'b0, 32'd906);
    push_at(1'b1, 32'd950);
    push_at(1'b1, 32'd956);
    push_at(1'b1, 32'd1500);
    push_at(1'b0, 32'hFFFF_FFF0);
    push_at(1'b0, 32'hFFFF_FFFF);
    push_at(1'b1, 32'h0000_0002);
    push_at(1'b1, 32'h0000_0009);
    push_at(1'b1, 32'h0000_0000);
    push_at(1'b0, 32'h0000_0000);
    push_at(1'b0, 32'h8000_0000);
    wait_drained();

    clock_ms = $urandom;
    queue_random(100);
    wait_drained();

    calm = 1'b1;
    configure(1'b0, 16'd0, 16'hFFFF, 16'd0);
    queue_random(80);
    wait_drained();
    calm = 1'b0;

    configure(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
    clock_ms = 32'hFFF0_0000;
    queue_random(60);
    wait_drained();

    configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    queue_random(80);
    wait_drained();

    configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 20)),
              16'($urandom_range(0, 400)), 16'($urandom_range(0, 1000)));
    queue_random(80);
    wait_drained();

    if (err_count == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bde_pkg.sv
src/bde_eval.sv
src/bde_evq.sv
src/button_debounce_event_detector.sv
test/testbench.sv
